// ===== src/phtp_pkg.sv =====
// Package for the PES header and timestamp parser.
// Holds widths, header byte offsets, stream id masks, status codes and the
// struct that carries a closed packet from the capture stage to the result stage.
package phtp_pkg;

	localparam int COUNT_BITS = 20;
	localparam int ES_BITS    = 20;
	localparam int TS_BITS    = 33;
	localparam int CALC_BITS  = ((COUNT_BITS > ES_BITS) ? COUNT_BITS : ES_BITS) + 1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Byte offsets inside the PES packet
	localparam logic [COUNT_BITS-1:0] OFS_SC0     = COUNT_BITS'(0);
	localparam logic [COUNT_BITS-1:0] OFS_SC1     = COUNT_BITS'(1);
	localparam logic [COUNT_BITS-1:0] OFS_SC2     = COUNT_BITS'(2);
	localparam logic [COUNT_BITS-1:0] OFS_ID      = COUNT_BITS'(3);
	localparam logic [COUNT_BITS-1:0] OFS_LEN_HI  = COUNT_BITS'(4);
	localparam logic [COUNT_BITS-1:0] OFS_LEN_LO  = COUNT_BITS'(5);
	localparam logic [COUNT_BITS-1:0] OFS_FLAGS   = COUNT_BITS'(7);
	localparam logic [COUNT_BITS-1:0] OFS_HDR_LEN = COUNT_BITS'(8);
	localparam logic [COUNT_BITS-1:0] OFS_PTS     = COUNT_BITS'(9);
	localparam logic [COUNT_BITS-1:0] OFS_DTS     = COUNT_BITS'(14);
	localparam logic [COUNT_BITS-1:0] OFS_END     = COUNT_BITS'(19);

	localparam logic [7:0] START_ZERO = 8'h00;
	localparam logic [7:0] START_ONE  = 8'h01;
	localparam logic [7:0] AUDIO_MASK = 8'hE0;
	localparam logic [7:0] AUDIO_ID   = 8'hC0;
	localparam logic [7:0] VIDEO_MASK = 8'hF0;
	localparam logic [7:0] VIDEO_ID   = 8'hE0;

	localparam logic [1:0] FLAGS_PTS     = 2'd2;
	localparam logic [1:0] FLAGS_PTS_DTS = 2'd3;

	localparam int MIN_HEADER = 9;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_ID     = 3'd1;
	localparam logic [2:0] ST_SHORT      = 3'd2;
	localparam logic [2:0] ST_HDR_LONG   = 3'd3;
	localparam logic [2:0] ST_PKT_LONG   = 3'd4;
	localparam logic [2:0] ST_NO_TS      = 3'd5;

	typedef struct packed {
		logic                  fire;
		logic                  header_ok;
		logic [COUNT_BITS-1:0] size;
		logic [15:0]           packet_length;
		logic [7:0]            header_length;
		logic [1:0]            flags;
		logic [TS_BITS-1:0]    pts;
		logic [TS_BITS-1:0]    dts;
	} phtp_close_t;

endpackage

// ===== src/phtp_capture.sv =====
// Per-packet capture state: byte counter, header checks and timestamp assembly.
// Depends on phtp_pkg; presents the closed packet to the result stage.
module phtp_capture (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                first_byte,
	input  logic                last_byte,
	output phtp_pkg::phtp_close_t close
);
	import phtp_pkg::*;

	logic [COUNT_BITS-1:0] count_q, count_d, idx;
	logic                  collecting_q;
	logic                  header_ok_q, header_ok_d;
	logic [15:0]           plen_q, plen_d;
	logic [1:0]            flags_q, flags_d;
	logic [7:0]            hlen_q, hlen_d;
	logic [TS_BITS-1:0]    pts_q, pts_d, dts_q, dts_d;
	logic                  run;
	logic [COUNT_BITS-1:0] ts_ofs;
	logic [2:0]            ts_k;
	logic                  in_pts, in_dts;
	logic [TS_BITS-1:0]    ts_acc, ts_new;

	assign run = first_byte | collecting_q;
	assign idx = first_byte ? '0 : count_q;

	assign in_pts = (idx >= OFS_PTS) && (idx < OFS_DTS);
	assign in_dts = (idx >= OFS_DTS) && (idx < OFS_END);
	assign ts_ofs = idx - (in_dts ? OFS_DTS : OFS_PTS);
	assign ts_k   = ts_ofs[2:0];
	assign ts_acc = in_dts ? (first_byte ? '0 : dts_q) : (first_byte ? '0 : pts_q);

	// Drop the marker bits and place the byte into its slice of the 33-bit value
	always_comb begin
		ts_new = ts_acc;
		case (ts_k)
			3'd0: ts_new[32:30] = data_byte[3:1];
			3'd1: ts_new[29:22] = data_byte;
			3'd2: ts_new[21:15] = data_byte[7:1];
			3'd3: ts_new[14:7]  = data_byte;
			default: ts_new[6:0] = data_byte[7:1];
		endcase
	end

	always_comb begin
		header_ok_d = first_byte ? 1'b1 : header_ok_q;
		plen_d      = first_byte ? '0 : plen_q;
		flags_d     = first_byte ? '0 : flags_q;
		hlen_d      = first_byte ? '0 : hlen_q;
		pts_d       = first_byte ? '0 : pts_q;
		dts_d       = first_byte ? '0 : dts_q;

		if ((idx == OFS_SC0 || idx == OFS_SC1) && data_byte != START_ZERO)
			header_ok_d = 1'b0;
		if (idx == OFS_SC2 && data_byte != START_ONE)
			header_ok_d = 1'b0;
		if (idx == OFS_ID && (data_byte & AUDIO_MASK) != AUDIO_ID
				&& (data_byte & VIDEO_MASK) != VIDEO_ID)
			header_ok_d = 1'b0;
		if (idx == OFS_LEN_HI)
			plen_d[15:8] = data_byte;
		if (idx == OFS_LEN_LO)
			plen_d[7:0] = data_byte;
		if (idx == OFS_FLAGS)
			flags_d = data_byte[7:6];
		if (idx == OFS_HDR_LEN)
			hlen_d = data_byte;
		if (in_pts)
			pts_d = ts_new;
		if (in_dts)
			dts_d = ts_new;

		// Saturate the count
		count_d = (idx < COUNT_MAX) ? idx + COUNT_BITS'(1) : idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			collecting_q <= 1'b0;
			header_ok_q  <= 1'b0;
			plen_q       <= '0;
			flags_q      <= '0;
			hlen_q       <= '0;
			pts_q        <= '0;
			dts_q        <= '0;
		end else if (accept && run) begin
			count_q      <= count_d;
			collecting_q <= ~last_byte;
			header_ok_q  <= header_ok_d;
			plen_q       <= plen_d;
			flags_q      <= flags_d;
			hlen_q       <= hlen_d;
			pts_q        <= pts_d;
			dts_q        <= dts_d;
		end
	end

	assign close.fire          = accept & run & last_byte;
	assign close.header_ok     = header_ok_d;
	assign close.size          = count_d;
	assign close.packet_length = plen_d;
	assign close.header_length = hlen_d;
	assign close.flags         = flags_d;
	assign close.pts           = pts_d;
	assign close.dts           = dts_d;

endmodule

// ===== src/phtp_result.sv =====
// Status decision and result register with valid/ready output.
// Depends on phtp_pkg; takes the closed packet from phtp_capture.
module phtp_result (
	input  logic                          clk,
	input  logic                          arst_n,
	input  phtp_pkg::phtp_close_t         close,
	output logic                          free,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [phtp_pkg::TS_BITS-1:0]  pts_value,
	output logic [phtp_pkg::TS_BITS-1:0]  dts_value,
	output logic                          dts_present,
	output logic [phtp_pkg::ES_BITS-1:0]  es_length
);
	import phtp_pkg::*;

	logic [CALC_BITS-1:0] size_w, hl_w, pl_w, hdr_end, pkt_end, es_calc;
	logic [2:0]           status_d;
	logic                 ok;
	logic                 valid_q;
	logic [2:0]           status_q;
	logic [TS_BITS-1:0]   pts_q, dts_q;
	logic                 dts_present_q;
	logic [ES_BITS-1:0]   es_q;

	assign size_w  = CALC_BITS'(close.size);
	assign hl_w    = CALC_BITS'(close.header_length);
	assign pl_w    = CALC_BITS'(close.packet_length);
	assign hdr_end = hl_w + CALC_BITS'(MIN_HEADER);
	assign pkt_end = pl_w + hdr_end;
	assign es_calc = (pl_w != '0) ? pl_w : size_w - hdr_end;

	always_comb begin
		if (size_w >= CALC_BITS'(4) && !close.header_ok)
			status_d = ST_BAD_ID;
		else if (size_w < CALC_BITS'(MIN_HEADER))
			status_d = ST_SHORT;
		else if (size_w < hdr_end)
			status_d = ST_HDR_LONG;
		else if (pl_w != '0 && pkt_end > size_w)
			status_d = ST_PKT_LONG;
		else if (close.flags == FLAGS_PTS && size_w >= CALC_BITS'(OFS_DTS))
			status_d = ST_OK;
		else if (close.flags == FLAGS_PTS_DTS && size_w >= CALC_BITS'(OFS_END))
			status_d = ST_OK;
		else
			status_d = ST_NO_TS;
	end

	assign ok   = (status_d == ST_OK);
	assign free = ~valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= close.fire;
		end
	end

	// Load a new result only when the register is free
	always_ff @(posedge clk) begin
		if (free && close.fire) begin
			status_q      <= status_d;
			pts_q         <= ok ? close.pts : '0;
			dts_q         <= (ok && close.flags == FLAGS_PTS_DTS) ? close.dts : '0;
			dts_present_q <= ok && close.flags == FLAGS_PTS_DTS;
			es_q          <= ok ? es_calc[ES_BITS-1:0] : '0;
		end
	end

	assign out_valid   = valid_q;
	assign status      = status_q;
	assign pts_value   = pts_q;
	assign dts_value   = dts_q;
	assign dts_present = dts_present_q;
	assign es_length   = es_q;

endmodule

// ===== src/pes_header_timestamp_parser.sv =====
// Top level of the PES header and timestamp parser.
// Depends on phtp_pkg, phtp_capture and phtp_result.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    data_byte, first_byte, last_byte
//   out       out_valid / out_ready  status, pts_value, dts_value, dts_present, es_length
//
// One byte is taken per cycle while in_ready is high; a packet's result
// sits in the output register the cycle after its closing byte is accepted.
// Reset clears the packet state and the output valid flag.
// in_ready drops only while a result waits in the output register and
// out_ready is low; the register is reloaded in the cycle it is taken.
module pes_header_timestamp_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          first_byte,
	input  logic                          last_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [phtp_pkg::TS_BITS-1:0]  pts_value,
	output logic [phtp_pkg::TS_BITS-1:0]  dts_value,
	output logic                          dts_present,
	output logic [phtp_pkg::ES_BITS-1:0]  es_length
);
	import phtp_pkg::*;

	phtp_close_t close;
	logic        free;

	assign in_ready = free;

	phtp_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_valid & free),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.close      (close)
	);

	phtp_result u_result (
		.clk         (clk),
		.arst_n      (arst_n),
		.close       (close),
		.free        (free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.pts_value   (pts_value),
		.dts_value   (dts_value),
		.dts_present (dts_present),
		.es_length   (es_length)
	);

endmodule
